// ===== sv/text_console_cursor_scroll_macros.svh =====
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shorthand for clocked implications used by the console port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// same-cycle implication, gated by reset
`define TCCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console check failed");

// next-cycle implication, gated by reset
`define TCCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console check failed");

`endif

// ===== sv/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Field widths, character codes, op codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int OP_W      = 2;
  localparam int CH_W      = 8;
  localparam int RROW_W    = 5;
  localparam int RCOL_W    = 7;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int IN_TDATA_W  = 24;   // ch, read_row, read_col, pad
  localparam int OUT_TDATA_W = 40;   // serial_byte, cell_value, cursor_row, cursor_col, pad
  localparam int NRES_W    = 2;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_BLANK};

  typedef struct packed {
    logic              accept;  // latch the incoming request
    logic              exec;    // evaluate the latched request
    logic              sweep;   // write one cell of the blanking sweep
    logic              load;    // load one result into the output register
    logic              last;    // the loaded result is the final one
    logic [NRES_W-1:0] idx;     // which echo byte to load
  } ctrl_cmd_t;

  typedef struct packed {
    logic              need_sweep;  // scroll or clear pending (valid during exec)
    logic              sweep_last;  // sweep is at its final cell
    logic              out_free;    // output register can take a result
    logic [NRES_W-1:0] n_res;       // result count of the current request
  } dp_stat_t;

endpackage

// ===== sv/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console controller
// Sequences accept, execute, screen sweep and result emission.
// ----------------------------------------------------------------------------
module tccs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tccs_pkg::dp_stat_t   stat,
  output tccs_pkg::ctrl_cmd_t  cmd
);
  import tccs_pkg::*;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NRES_W-1:0] k_r, k_nxt;
  logic              at_last;

  assign at_last   = (k_r == (stat.n_res - NRES_W'(1)));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cmd        = '0;
    cmd.idx    = k_r;
    cmd.last   = at_last;
    case (state_r)
      S_INIT: begin
        // power-up blanking pass over the whole screen
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        k_nxt     = '0;
        state_nxt = stat.need_sweep ? S_SWEEP : S_EMIT;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          k_nxt    = k_r + NRES_W'(1);
          if (at_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== sv/tccs_dpath.sv =====
// ----------------------------------------------------------------------------
// Text console datapath
// Screen store, cursor, scroll base, blanking sweep and output register.
// ----------------------------------------------------------------------------
module tccs_dpath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tccs_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [tccs_pkg::OP_W-1:0]          in_tuser,
  input  logic                               cfg_valid,
  input  logic [tccs_pkg::ATTR_W-1:0]        cfg_data,
  input  tccs_pkg::ctrl_cmd_t                cmd,
  output tccs_pkg::dp_stat_t                 stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tccs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import tccs_pkg::*;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int TOTAL  = ROWS * COLS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam logic [ROW_W:0]    ROWS_V   = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);

  // logical row plus scroll base, wrapped, then flattened to a cell index
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= ROWS_V) sum = sum - ROWS_V;
    return ADDR_W'(32'(sum[ROW_W-1:0]) * COLS) + ADDR_W'(col);
  endfunction

  // latched request
  logic [OP_W-1:0]   op_r;
  logic [CH_W-1:0]   ch_r;
  logic [RROW_W-1:0] rrow_r;
  logic [RCOL_W-1:0] rcol_r;

  logic [ATTR_W-1:0] attr_r;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;

  logic [ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [ADDR_W-1:0] sweep_end_r, sweep_end_nxt;
  logic [CELL_W-1:0] sweep_data_r;

  logic [CH_W-1:0]   echo0_r, echo1_r, echo2_r;
  logic [CH_W-1:0]   echo0_nxt, echo1_nxt, echo2_nxt;
  logic [NRES_W-1:0] n_res_r, n_res_nxt;
  logic              serial_r, serial_nxt;
  logic              cell_ok_r, cell_ok_nxt;

  logic [CELL_W-1:0] mem [TOTAL];
  logic [CELL_W-1:0] mem_q_r;

  logic              out_valid_r;
  logic              out_serial_r;
  logic [CH_W-1:0]   out_byte_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [RROW_W-1:0] out_row_r;
  logic [RCOL_W-1:0] out_col_r;
  logic              out_last_r;

  logic [CELL_W-1:0] blank_cell;
  logic              ex_we;
  logic [ADDR_W-1:0] ex_waddr;
  logic [CELL_W-1:0] ex_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;
  logic              newline, wrapped, scroll, clear;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CH_W-1:0]   sel_byte;
  logic [ADDR_W-1:0] top_addr;

  assign blank_cell  = {attr_r, CH_BLANK};
  assign rd_in_range = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLS);
  assign rd_addr     = cell_addr(ROW_W'(rrow_r), COL_W'(rcol_r), base_r);
  assign top_addr    = cell_addr('0, '0, base_r);

  always_comb begin
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    base_nxt       = base_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_end_nxt  = sweep_end_r;
    echo0_nxt      = '0;
    echo1_nxt      = '0;
    echo2_nxt      = '0;
    n_res_nxt      = NRES_W'(1);
    serial_nxt     = 1'b0;
    cell_ok_nxt    = 1'b0;
    ex_we          = 1'b0;
    ex_waddr       = cell_addr(cur_row_r, cur_col_r, base_r);
    ex_wdata       = {attr_r, ch_r};
    newline        = 1'b0;
    wrapped        = 1'b0;
    scroll         = 1'b0;
    clear          = 1'b0;
    case (op_r)
      OP_PUT: begin
        serial_nxt = 1'b1;
        case (ch_r)
          CH_NL: newline = 1'b1;
          CH_CR: begin
            cur_col_nxt = '0;
            echo0_nxt   = CH_CR;
          end
          CH_BS: begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - COL_W'(1);
              ex_we       = 1'b1;
              ex_waddr    = cell_addr(cur_row_r, cur_col_r - COL_W'(1), base_r);
              ex_wdata    = blank_cell;
            end
            echo0_nxt = CH_BS;
          end
          default: begin
            ex_we     = 1'b1;
            echo0_nxt = ch_r;
            if (cur_col_r == LAST_COL) begin
              newline = 1'b1;
              wrapped = 1'b1;
            end else begin
              cur_col_nxt = cur_col_r + COL_W'(1);
            end
          end
        endcase
      end
      OP_READ:  cell_ok_nxt = rd_in_range;
      OP_CLEAR: begin
        clear       = 1'b1;
        cur_row_nxt = '0;
        cur_col_nxt = '0;
        base_nxt    = '0;
      end
      default: ;
    endcase

    if (newline) begin
      cur_col_nxt = '0;
      if (wrapped) begin
        echo1_nxt = CH_CR;
        echo2_nxt = CH_NL;
        n_res_nxt = NRES_W'(3);
      end else begin
        echo0_nxt = CH_CR;
        echo1_nxt = CH_NL;
        n_res_nxt = NRES_W'(2);
      end
      if (cur_row_r == LAST_ROW) begin
        // old top row becomes the new bottom row and gets blanked
        scroll   = 1'b1;
        base_nxt = (base_r == LAST_ROW) ? '0 : base_r + ROW_W'(1);
      end else begin
        cur_row_nxt = cur_row_r + ROW_W'(1);
      end
    end

    if (scroll) begin
      sweep_addr_nxt = top_addr;
      sweep_end_nxt  = top_addr + ADDR_W'(COLS - 1);
    end else if (clear) begin
      sweep_addr_nxt = '0;
      sweep_end_nxt  = LAST_ADDR;
    end
  end

  assign stat.need_sweep = scroll | clear;
  assign stat.sweep_last = (sweep_addr_r == sweep_end_r);
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.n_res      = n_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r       <= ATTR_RESET;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      base_r       <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= LAST_ADDR;
      sweep_data_r <= RESET_BLANK;
      n_res_r      <= NRES_W'(1);
    end else begin
      if (cfg_valid) attr_r <= cfg_data;
      if (cmd.exec) begin
        cur_row_r    <= cur_row_nxt;
        cur_col_r    <= cur_col_nxt;
        base_r       <= base_nxt;
        sweep_addr_r <= sweep_addr_nxt;
        sweep_end_r  <= sweep_end_nxt;
        sweep_data_r <= blank_cell;
        n_res_r      <= n_res_nxt;
      end else if (cmd.sweep && !stat.sweep_last) begin
        sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_tuser;
      ch_r   <= in_tdata[7:0];
      rrow_r <= in_tdata[12:8];
      rcol_r <= in_tdata[19:13];
    end
    if (cmd.exec) begin
      echo0_r   <= echo0_nxt;
      echo1_r   <= echo1_nxt;
      echo2_r   <= echo2_nxt;
      serial_r  <= serial_nxt;
      cell_ok_r <= cell_ok_nxt;
    end
  end

  // screen store: one write port, one registered read port
  assign mem_we    = cmd.sweep || (cmd.exec && ex_we);
  assign mem_waddr = cmd.sweep ? sweep_addr_r : ex_waddr;
  assign mem_wdata = cmd.sweep ? sweep_data_r : ex_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.exec && op_r == OP_READ && rd_in_range) mem_q_r <= mem[rd_addr];
  end

  always_comb begin
    case (cmd.idx)
      NRES_W'(0): sel_byte = echo0_r;
      NRES_W'(1): sel_byte = echo1_r;
      default:    sel_byte = echo2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_serial_r <= serial_r;
      out_byte_r   <= serial_r ? sel_byte : '0;
      out_cell_r   <= (!serial_r && cell_ok_r) ? mem_q_r : '0;
      out_row_r    <= RROW_W'(cur_row_r);
      out_col_r    <= RCOL_W'(cur_col_r);
      out_last_r   <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_serial_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_col_r, out_row_r, out_cell_r, out_byte_r};

endmodule

// ===== sv/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// Text console with cursor, scroll and serial echo
// Character-cell screen store with cursor control and echoed byte stream.
// ----------------------------------------------------------------------------
// A taken request is latched, evaluated in the execute state, and its results (1..3) loaded
// one by one into the output register in the emit state whenever that register is free;
// a new request is taken only after the last result is loaded. A scroll blanks COLS
// cells and a clear blanks ROWS*COLS cells, one cell written per cycle through the
// single write port of the screen store. After reset a blanking pass over all ROWS*COLS
// cells (2000 at 80x25) runs with in_tready low; configuration writes are taken during it.
module text_console_cursor_scroll #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tccs_pkg::IN_TDATA_W-1:0]   in_tdata,   // ch[7:0], read_row[12:8], read_col[19:13]
  input  logic [tccs_pkg::OP_W-1:0]         in_tuser,   // op[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tccs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // serial_byte[7:0], cell_value[23:8],
                                                        // cursor_row[28:24], cursor_col[35:29]
  output logic                              out_tuser,  // serial_valid[0]
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tccs_pkg::ATTR_W-1:0]       cfg_data    // attribute[7:0]
);
  import tccs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tccs_dpath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/tccs_chk.sv =====
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the result stream of the console for consistency over time.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_macros.svh"

module tccs_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tccs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);

  // a stalled result holds
  `TCCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // no echo means no echoed byte
  `TCCS_ASSERT_SAME(a_no_echo_byte, out_tvalid && !out_tuser, out_tdata[7:0] == 8'h00)

  // echoed results never carry a cell
  `TCCS_ASSERT_SAME(a_echo_no_cell, out_tvalid && out_tuser, out_tdata[23:8] == 16'h0000)

  // results of one request follow back to back with the same cursor
  `TCCS_ASSERT_NEXT(a_burst_cursor, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tuser && (out_tdata[35:24] == $past(out_tdata[35:24])))

endmodule

bind text_console_cursor_scroll tccs_chk u_tccs_chk (.*);

// ===== sim/tb_text_console_cursor_scroll.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console testbench
// Directed table then random request runs against a shadow screen/cursor
// model; every echoed byte, read cell and cursor position is compared.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;
  import tccs_pkg::*;

  localparam int ROWS          = 25;
  localparam int COLS          = 80;
  localparam int SETTLE_CYCLES = ROWS * COLS + 16;  // idle margin before a register write
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 30;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef enum int {SEG_TEXT, SEG_LONG, SEG_SCROLL, SEG_READ, SEG_NOISE} seg_kind_t;

  typedef struct packed {
    logic              serial_valid;
    logic [CH_W-1:0]   serial_byte;
    logic [CELL_W-1:0] cell_value;
    logic [4:0]        cursor_row;
    logic [6:0]        cursor_col;
    logic              last;
  } console_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [RROW_W-1:0] rd_row;
    logic [RCOL_W-1:0] rd_col;
    logic              typed;     // exp_cell holds the cell value to expect
    logic [CELL_W-1:0] exp_cell;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  // typed rows come before any put, so the cursor is still home
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_READ,  8'h00,  5'd0,  7'd0,   1'b1, RESET_BLANK},
    '{OP_READ,  8'h00,  5'd24, 7'd79,  1'b1, RESET_BLANK},
    '{OP_READ,  8'h00,  5'd25, 7'd0,   1'b1, 16'h0000},
    '{OP_READ,  8'h00,  5'd0,  7'd80,  1'b1, 16'h0000},
    '{OP_READ,  8'hFF,  5'd31, 7'd127, 1'b1, 16'h0000},
    '{OP_SPARE, 8'hFF,  5'd31, 7'd127, 1'b1, 16'h0000},
    '{OP_PUT,   8'h41,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_PUT,   8'hFF,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_PUT,   8'h80,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_PUT,   8'h00,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_PUT,   CH_BS,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_READ,  8'h00,  5'd0,  7'd2,   1'b0, 16'h0000},
    '{OP_READ,  8'h00,  5'd0,  7'd3,   1'b0, 16'h0000},
    '{OP_PUT,   CH_CR,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_PUT,   CH_BS,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_READ,  8'h00,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_READ,  8'h00,  5'd0,  7'd1,   1'b0, 16'h0000},
    '{OP_PUT,   CH_NL,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_PUT,   8'h7E,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_SPARE, 8'h00,  5'd0,  7'd0,   1'b0, 16'h0000},
    '{OP_READ,  8'h00,  5'd1,  7'd0,   1'b0, 16'h0000},
    '{OP_CLEAR, 8'hFF,  5'd31, 7'd127, 1'b0, 16'h0000},
    '{OP_READ,  8'h00,  5'd1,  7'd0,   1'b0, 16'h0000}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // ch[7:0], read_row[12:8], read_col[19:13]
  logic [OP_W-1:0]        in_tuser = '0;    // op[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // serial_byte, cell_value, cursor_row, cursor_col
  logic                   out_tuser;        // serial_valid[0]
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [ATTR_W-1:0]      cfg_data = '0;    // attribute[7:0]

  text_console_cursor_scroll #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow console state
  logic [CELL_W-1:0] shadow_screen [ROWS*COLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] cur_attr;
  logic [CH_W-1:0]   echo_buf [3];
  int                echo_cnt;
  console_result_t   expected_q [$];
  int                mismatches = 0;

  // sender / receiver pacing
  int burst_left = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {cur_attr, CH_BLANK};
  endfunction

  task automatic echo_byte(input logic [CH_W-1:0] b);
    echo_buf[echo_cnt] = b;
    echo_cnt++;
  endtask

  task automatic line_feed();
    int i;
    cur_col = 0;
    echo_byte(CH_CR);
    echo_byte(CH_NL);
    cur_row++;
    if (cur_row >= ROWS) begin
      for (i = 0; i < (ROWS - 1) * COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (i = 0; i < COLS; i++) shadow_screen[(ROWS - 1) * COLS + i] = blank_cell();
      cur_row = ROWS - 1;
    end
  endtask

  task automatic console_step(input stim_row_t s);
    logic [CELL_W-1:0] rd_cell;
    console_result_t   r;
    int                i;
    int                n;
    echo_cnt = 0;
    rd_cell = '0;
    case (s.op)
      OP_PUT: begin
        if (s.ch == CH_NL) begin
          line_feed();
        end else if (s.ch == CH_CR) begin
          cur_col = 0;
          echo_byte(CH_CR);
        end else if (s.ch == CH_BS) begin
          if (cur_col != 0) begin
            cur_col--;
            shadow_screen[cur_row * COLS + cur_col] = blank_cell();
          end
          echo_byte(CH_BS);
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {cur_attr, s.ch};
          echo_byte(s.ch);
          cur_col++;
          if (cur_col >= COLS) line_feed();
        end
      end
      OP_READ: begin
        if (int'(s.rd_row) < ROWS && int'(s.rd_col) < COLS)
          rd_cell = shadow_screen[s.rd_row * COLS + s.rd_col];
      end
      OP_CLEAR: begin
        for (i = 0; i < ROWS * COLS; i++) shadow_screen[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    if (s.typed) rd_cell = s.exp_cell;
    n = (echo_cnt > 0) ? echo_cnt : 1;
    for (i = 0; i < n; i++) begin
      r.serial_valid = (echo_cnt > 0);
      r.serial_byte  = (echo_cnt > 0) ? echo_buf[i] : '0;
      r.cell_value   = (echo_cnt > 0) ? '0 : rd_cell;
      r.cursor_row   = cur_row[4:0];
      r.cursor_col   = cur_col[6:0];
      r.last         = (i == n - 1);
      expected_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got_v, exp_v);
    mismatches++;
  endtask

  task automatic check_result();
    console_result_t e;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result (serial_byte)", out_tdata[7:0], 0);
    end else begin
      e = expected_q.pop_front();
      if (out_tuser !== e.serial_valid) report_mismatch("serial_valid", out_tuser, e.serial_valid);
      if (out_tdata[7:0] !== e.serial_byte)
        report_mismatch("serial_byte", out_tdata[7:0], e.serial_byte);
      if (out_tdata[23:8] !== e.cell_value)
        report_mismatch("cell_value", out_tdata[23:8], e.cell_value);
      if (out_tdata[28:24] !== e.cursor_row)
        report_mismatch("cursor_row", out_tdata[28:24], e.cursor_row);
      if (out_tdata[35:29] !== e.cursor_col)
        report_mismatch("cursor_col", out_tdata[35:29], e.cursor_col);
      if (out_tlast !== e.last) report_mismatch("last", out_tlast, e.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // receiver: stall pattern whose mode is picked at random and changed from time to time,
  // plus one long hold-off on request
  initial begin : receiver
    int pat_mode;
    int pat_left;
    pat_mode = 0;
    pat_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 80);
        end
        pat_left--;
        case (pat_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_request(input stim_row_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= s.op;
    in_tdata  <= {4'b0, s.rd_col, s.rd_row, s.ch};
    do @(posedge clk); while (!in_tready);
    console_step(s);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                         input int rr, input int rc);
    stim_row_t s;
    s = '{op, ch, rr[RROW_W-1:0], rc[RCOL_W-1:0], 1'b0, 16'h0000};
    send_request(s);
  endtask

  function automatic logic [CH_W-1:0] pick_glyph();
    logic [CH_W-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_NL || b == CH_CR || b == CH_BS);
    return b;
  endfunction

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_attr = v;
  endtask

  // one random phase; the opening segment is forced
  task automatic run_random(input seg_kind_t first_kind, input int n_items);
    seg_kind_t kind;
    int        sent;
    int        len;
    int        k;
    int        r;
    int        rr;
    bit        opening;
    kind = first_kind;
    opening = 1'b1;
    sent = 0;
    while (opening || sent < n_items) begin
      case (kind)
        SEG_TEXT: begin
          len = $urandom_range(1, 12);
          for (k = 0; k < len; k++) begin
            r = $urandom_range(0, 19);
            send_op(OP_PUT, (r == 0) ? CH_BS : (r == 1) ? CH_CR : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 31), $urandom_range(0, 127));
          end
        end
        SEG_LONG: begin
          // nearly a full line or more, so it can wrap past the last column
          len = $urandom_range(78, 84);
          for (k = 0; k < len; k++) send_op(OP_PUT, pick_glyph(), 0, 0);
        end
        SEG_SCROLL: begin
          len = $urandom_range(26, 30);
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 1) == 1) send_op(OP_PUT, pick_glyph(), 0, 0);
            send_op(OP_PUT, CH_NL, 0, 0);
          end
        end
        SEG_READ: begin
          len = $urandom_range(1, 4);
          for (k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
              // near the cursor, where the text is
              rr = cur_row - $urandom_range(0, 2);
              send_op(OP_READ, 8'($urandom_range(0, 255)), (rr < 0) ? 0 : rr,
                      $urandom_range(0, (cur_col > 0) ? cur_col : 1));
            end else if (r < 9) begin
              send_op(OP_READ, 8'h00, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
            end else begin
              send_op(OP_READ, 8'h00, $urandom_range(0, 31), $urandom_range(0, 127));
            end
          end
        end
        default: begin
          len = 1;
          r = $urandom_range(0, 9);
          if (r < 3) send_op(OP_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                             $urandom_range(0, 127));
          else send_op(OP_SPARE, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                       $urandom_range(0, 127));
        end
      endcase
      sent += len;
      opening = 1'b0;
      r = $urandom_range(0, 99);
      kind = (r < 40) ? SEG_TEXT : (r < 44) ? SEG_LONG : (r < 48) ? SEG_SCROLL :
             (r < 85) ? SEG_READ : SEG_NOISE;
    end
  endtask

  initial begin : stimulus
    int i;
    cur_attr = ATTR_RESET;
    for (i = 0; i < ROWS * COLS; i++) shadow_screen[i] = RESET_BLANK;
    cur_row = 0;
    cur_col = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // wait out the blanking pass after reset
    do @(posedge clk); while (!in_tready);

    for (i = 0; i < N_DIRECTED; i++) send_request(DIRECTED[i]);

    drain_and_settle();
    write_attribute(8'h00);
    run_random(SEG_SCROLL, PHASE_ITEMS);

    drain_and_settle();
    write_attribute(8'hFF);
    hold_req = 1'b1;
    run_random(SEG_LONG, PHASE_ITEMS);

    drain_and_settle();
    write_attribute(8'($urandom_range(1, 254)));
    steady = 1'b1;
    run_random(SEG_TEXT, PHASE_ITEMS / 2);
    steady = 1'b0;
    run_random(SEG_READ, PHASE_ITEMS / 2);

    in_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
